[design/anagram_pair_finder_unit_assert.svh]
// assertion macros for the anagram pair finder
// no dependencies; taken in by the top level with an include
`ifndef ANAGRAM_PAIR_FINDER_UNIT_ASSERT_SVH
`define ANAGRAM_PAIR_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define APF_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APF_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[design/apf_pkg.sv]
// shared types and constants for the anagram pair finder
// no dependencies; used by apf_ctrl, apf_dpath and the top level
package apf_pkg;

  localparam int ALPHABET  = 26;
  localparam int START_W   = 7;
  localparam int LEN_OUT_W = 8;
  localparam int TOTAL_W   = 11;
  localparam int EMIT_W    = 6;

  localparam logic [7:0] UPPER_A = 8'd65;
  localparam logic [7:0] UPPER_Z = 8'd90;
  localparam logic [7:0] LOWER_A = 8'd97;
  localparam logic [7:0] LOWER_Z = 8'd122;

  // at most this many pair words per input byte
  localparam logic [EMIT_W-1:0]  EMIT_CAP = 6'd63;
  localparam logic [TOTAL_W-1:0] PAIR_SAT = 11'd2047;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_STORE,
    ST_FLUSH,
    ST_RPT
  } state_t;

  typedef enum logic {
    OUT_PEND,
    OUT_REPORT
  } out_sel_t;

  typedef struct packed {
    logic     take_byte;
    logic     scan_read;
    logic     scan_step;
    logic     store_word;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_last;
    logic     clear_all;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic word_full;
    logic last_in;
    logic last_q;
    logic scan_done;
    logic match;
    logic cap_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

[design/apf_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module apf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/apf_ctrl.sv]
// sequencer for the anagram pair finder: byte intake, scan, store, output
// depends on apf_pkg
module apf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  apf_pkg::sts_t sts,
  output apf_pkg::cmd_t cmd
);
  import apf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = OUT_PEND;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (sts.finish && !sts.word_full) begin
            state_next = ST_RD;
          end else if (sts.last_in) begin
            state_next = ST_RPT;
          end
        end
      end
      ST_RD: begin
        if (sts.scan_done) begin
          state_next = ST_STORE;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = ST_CMP;
        end
      end
      ST_CMP: begin
        // a new match displaces the held pair, which needs a free output
        if (!(sts.match && sts.cap_ok && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if (sts.match && sts.cap_ok && sts.pend_valid) begin
            cmd.load_out = 1'b1;
            cmd.out_sel  = OUT_PEND;
            cmd.out_last = 1'b0;
          end
          state_next = ST_RD;
        end
      end
      ST_STORE: begin
        cmd.store_word = 1'b1;
        state_next     = sts.last_q ? ST_RPT : ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = OUT_PEND;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RPT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.pend_valid) begin
            cmd.out_sel  = OUT_PEND;
            cmd.out_last = 1'b0;
          end else begin
            cmd.out_sel   = OUT_REPORT;
            cmd.out_last  = 1'b1;
            cmd.clear_all = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/apf_dpath.sv]
// datapath: letter histogram, word store, scan compare, pair hold, output word
// depends on apf_pkg and apf_ram
module apf_dpath #(
  parameter int MAX_CHARS = 128,
  parameter int MAX_WORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      char_byte,
  input  logic                            end_of_text,
  input  apf_pkg::cmd_t                   cmd,
  output apf_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [apf_pkg::START_W-1:0]     first_start,
  output logic [apf_pkg::LEN_OUT_W-1:0]   first_length,
  output logic [apf_pkg::START_W-1:0]     second_start,
  output logic [apf_pkg::LEN_OUT_W-1:0]   second_length,
  output logic [apf_pkg::TOTAL_W-1:0]     pair_total,
  output logic                            overflow_seen,
  output logic                            last_of_run
);
  import apf_pkg::*;

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int CW = PW;
  localparam int WW = $clog2(MAX_WORDS + 1);
  localparam int AW = $clog2(MAX_WORDS);
  localparam int HW = ALPHABET * CW;
  localparam int RW = START_W + PW + HW;

  logic [PW-1:0]      pos;
  logic               in_word;
  logic [START_W-1:0] cur_start;
  logic [PW-1:0]      cur_len;
  logic [CW-1:0]      hist [ALPHABET];
  logic [HW-1:0]      hist_flat;
  logic [WW-1:0]      word_count;
  logic [WW-1:0]      scan_idx;
  logic [TOTAL_W-1:0] pair_counter;
  logic [TOTAL_W-1:0] pair_counter_next;
  logic               overflow_flag;
  logic [EMIT_W-1:0]  emitted;
  logic               last_q;

  logic               pend_valid;
  logic [START_W-1:0] pend_start;
  logic [PW-1:0]      pend_len;
  logic [TOTAL_W-1:0] pend_total;
  logic               pend_ovf;

  logic [RW-1:0]      rd_row;
  logic [RW-1:0]      wr_row;

  logic               processed;
  logic               is_upper;
  logic               is_lower;
  logic               is_letter;
  logic [4:0]         letter_idx;
  logic               in_word_after;
  logic               capture;

  // byte classification
  always_comb begin
    processed  = pos < PW'(MAX_CHARS);
    is_upper   = (char_byte >= UPPER_A) && (char_byte <= UPPER_Z);
    is_lower   = (char_byte >= LOWER_A) && (char_byte <= LOWER_Z);
    is_letter  = processed && (is_upper || is_lower);
    letter_idx = is_upper ? 5'(char_byte - UPPER_A) : 5'(char_byte - LOWER_A);
    in_word_after = in_word || is_letter;
  end

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      hist_flat[i*CW +: CW] = hist[i];
    end
  end

  assign wr_row = {cur_start, cur_len, hist_flat};
  assign pair_counter_next = (pair_counter == PAIR_SAT) ? pair_counter
                                                        : pair_counter + 11'd1;

  always_comb begin
    sts.finish     = (processed && !is_letter && in_word) || (end_of_text && in_word_after);
    sts.word_full  = word_count >= WW'(MAX_WORDS);
    sts.last_in    = end_of_text;
    sts.last_q     = last_q;
    sts.scan_done  = scan_idx == word_count;
    sts.match      = rd_row[HW-1:0] == hist_flat;
    sts.cap_ok     = emitted < EMIT_CAP;
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || out_ready;
  end

  assign capture = cmd.scan_step && sts.match && sts.cap_ok;

  apf_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_WORDS)
  ) u_words (
    .clk   (clk),
    .we    (cmd.store_word),
    .waddr (word_count[AW-1:0]),
    .wdata (wr_row),
    .re    (cmd.scan_read),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_row)
  );

  // sentence state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      pos           <= '0;
      in_word       <= 1'b0;
      cur_start     <= '0;
      cur_len       <= '0;
      word_count    <= '0;
      pair_counter  <= '0;
      overflow_flag <= 1'b0;
      last_q        <= 1'b0;
      for (int i = 0; i < ALPHABET; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (cmd.take_byte) begin
        last_q  <= end_of_text;
        in_word <= in_word_after && !sts.finish;
        if (processed) begin
          pos <= pos + PW'(1);
        end
        // dropped byte or dropped word
        if (!processed || (sts.finish && sts.word_full)) begin
          overflow_flag <= 1'b1;
        end
        if (is_letter) begin
          if (!in_word) begin
            cur_start <= START_W'(pos);
            cur_len   <= PW'(1);
          end else begin
            cur_len <= cur_len + PW'(1);
          end
          for (int i = 0; i < ALPHABET; i++) begin
            if (letter_idx == 5'(i)) begin
              hist[i] <= in_word ? hist[i] + CW'(1) : CW'(1);
            end else if (!in_word) begin
              hist[i] <= '0;
            end
          end
        end
      end
      if (capture) begin
        pair_counter <= pair_counter_next;
      end else if (cmd.scan_step && sts.match) begin
        pair_counter <= pair_counter_next;
      end
      if (cmd.store_word) begin
        word_count <= word_count + WW'(1);
      end
    end
  end

  // scan position and per-byte emit count
  always_ff @(posedge clk) begin
    if (rst || cmd.take_byte) begin
      scan_idx <= '0;
      emitted  <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + WW'(1);
      if (capture) begin
        emitted <= emitted + EMIT_W'(1);
      end
    end
  end

  // held pair: its last flag is known only when the next match or the end arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (capture) begin
      pend_valid <= 1'b1;
    end else if (cmd.load_out && cmd.out_sel == OUT_PEND) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      pend_start <= rd_row[RW-1 -: START_W];
      pend_len   <= rd_row[HW +: PW];
      pend_total <= pair_counter_next;
      pend_ovf   <= overflow_flag;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_of_run <= cmd.out_last;
      case (cmd.out_sel)
        OUT_PEND: begin
          result_kind   <= KIND_PAIR;
          first_start   <= pend_start;
          first_length  <= LEN_OUT_W'(pend_len);
          second_start  <= cur_start;
          second_length <= LEN_OUT_W'(cur_len);
          pair_total    <= pend_total;
          overflow_seen <= pend_ovf;
        end
        OUT_REPORT: begin
          result_kind   <= KIND_TOTAL;
          first_start   <= '0;
          first_length  <= '0;
          second_start  <= '0;
          second_length <= '0;
          pair_total    <= pair_counter;
          overflow_seen <= overflow_flag;
        end
        default: begin
          result_kind   <= KIND_TOTAL;
          first_start   <= '0;
          first_length  <= '0;
          second_start  <= '0;
          second_length <= '0;
          pair_total    <= pair_counter;
          overflow_seen <= overflow_flag;
        end
      endcase
    end
  end

endmodule

[design/anagram_pair_finder_unit.sv]
// anagram pair finder top level: sequencer plus datapath
// depends on apf_pkg, apf_ctrl, apf_dpath, apf_ram, anagram_pair_finder_unit_assert.svh
//
//  channel | handshake           | word contents
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid/in_ready   | char_byte, end_of_text
//  out     | out_valid/out_ready | result_kind, first/second start+length,
//          |                     | pair_total, overflow_seen, last_of_run
//
// a byte that ends no word is taken in idle; a last byte that ends no word then sends the report
// a word end reads and compares each stored word of the word ram in turn, then stores the word
//   and flushes the held pair; on the last byte a held pair goes out ahead of the total report
// results wait in one output register; a stalled output holds the scan on the next match
// reset is synchronous and clears all control state; the word ram needs no clearing
module anagram_pair_finder_unit #(
  parameter int MAX_CHARS = 128,
  parameter int MAX_WORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      char_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [apf_pkg::START_W-1:0]     first_start,
  output logic [apf_pkg::LEN_OUT_W-1:0]   first_length,
  output logic [apf_pkg::START_W-1:0]     second_start,
  output logic [apf_pkg::LEN_OUT_W-1:0]   second_length,
  output logic [apf_pkg::TOTAL_W-1:0]     pair_total,
  output logic                            overflow_seen,
  output logic                            last_of_run
);
  import apf_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  apf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  apf_dpath #(
    .MAX_CHARS(MAX_CHARS),
    .MAX_WORDS(MAX_WORDS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .char_byte     (char_byte),
    .end_of_text   (end_of_text),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .first_start   (first_start),
    .first_length  (first_length),
    .second_start  (second_start),
    .second_length (second_length),
    .pair_total    (pair_total),
    .overflow_seen (overflow_seen),
    .last_of_run   (last_of_run)
  );

  `include "anagram_pair_finder_unit_assert.svh"

  // the output register is only reloaded when it is empty or being drained
  `APF_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, sts.out_free, "output word overwritten")
  // a new match while a pair is held must push the held pair out
  `APF_ASSERT_IMP(a_pend_push, clk, rst,
    cmd.scan_step && sts.match && sts.cap_ok && sts.pend_valid,
    cmd.load_out && cmd.out_sel == OUT_PEND, "held pair lost")
  // a total report always closes the run
  `APF_ASSERT_IMP(a_report_last, clk, rst, out_valid && result_kind == KIND_TOTAL,
    last_of_run, "report without last flag")
  // the last byte of a sentence always leads to work before the next byte
  `APF_ASSERT_NEXT(a_eot_busy, clk, rst, in_valid && in_ready && end_of_text, !in_ready,
    "end of text taken without report")

endmodule

[tb/tb_anagram_pair_finder_unit.sv]
// self-checking testbench for anagram_pair_finder_unit: sentences in, pair and total words out
// depends on apf_pkg and the anagram_pair_finder_unit top level
// a built-in predictor of the letter-histogram matching checks every output word in order
module tb_anagram_pair_finder_unit;
  import apf_pkg::*;

  // block sizes at their defaults
  localparam int MAX_CHARS = 128;
  localparam int MAX_WORDS = 64;
  // quiet cycles allowed before the run is declared hung: a full scan, the long output
  // hold-off, sender gaps and stalls must all fit in this limit
  localparam int IDLE_LIMIT = 5000;
  // the long output hold-off starts once this many output words have gone by
  localparam int HOLD_AT    = 40;
  localparam int HOLD_LEN   = 400;
  localparam int RANDOM_ITEMS = 340;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic                 kind;
    logic [START_W-1:0]   fs;
    logic [LEN_OUT_W-1:0] fl;
    logic [START_W-1:0]   ss;
    logic [LEN_OUT_W-1:0] sl;
    logic [TOTAL_W-1:0]   total;
    logic                 ovf;
    logic                 last;
  } pair_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_TWO_OF_THREE,
    READY_SPARSE
  } stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           char_byte = 8'd0;
  logic                 end_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 result_kind;
  logic [START_W-1:0]   first_start;
  logic [LEN_OUT_W-1:0] first_length;
  logic [START_W-1:0]   second_start;
  logic [LEN_OUT_W-1:0] second_length;
  logic [TOTAL_W-1:0]   pair_total;
  logic                 overflow_seen;
  logic                 last_of_run;

  text_byte_t   text_queue [$];
  pair_result_t pending_results [$];
  int           errors = 0;

  anagram_pair_finder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_byte     (char_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .first_start   (first_start),
    .first_length  (first_length),
    .second_start  (second_start),
    .second_length (second_length),
    .pair_total    (pair_total),
    .overflow_seen (overflow_seen),
    .last_of_run   (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // predictor state: one sentence worth of letter runs
  // ------------------------------------------------------------------
  logic [7:0]           word_hist  [MAX_WORDS][ALPHABET];
  logic [START_W-1:0]   word_start [MAX_WORDS];
  logic [LEN_OUT_W-1:0] word_len   [MAX_WORDS];
  logic [7:0]           open_hist  [ALPHABET];
  logic [START_W-1:0]   open_start;
  logic [LEN_OUT_W-1:0] open_len;
  logic                 open_run;
  logic [7:0]           text_pos;
  logic [6:0]           run_count;
  logic [TOTAL_W-1:0]   pair_count;
  logic                 dropped;

  // letter number 0..25, or -1 for a separator byte
  function automatic int letter_index(input logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) return int'(c - UPPER_A);
    if (c >= LOWER_A && c <= LOWER_Z) return int'(c - LOWER_A);
    return -1;
  endfunction

  task automatic clear_sentence();
    int i;
    for (i = 0; i < ALPHABET; i++) open_hist[i] = 8'd0;
    open_start = '0;
    open_len   = '0;
    open_run   = 1'b0;
    text_pos   = '0;
    run_count  = '0;
    pair_count = '0;
    dropped    = 1'b0;
  endtask

  function automatic pair_result_t make_result(input logic kind, input logic [START_W-1:0] fs,
                                               input logic [LEN_OUT_W-1:0] fl,
                                               input logic [START_W-1:0] ss,
                                               input logic [LEN_OUT_W-1:0] sl);
    pair_result_t r;
    r.kind  = kind;
    r.fs    = fs;
    r.fl    = fl;
    r.ss    = ss;
    r.sl    = sl;
    r.total = pair_count;
    r.ovf   = dropped;
    r.last  = 1'b0;
    return r;
  endfunction

  // close the open run: match it against every stored run, then store it; drop it if full
  task automatic close_run(ref pair_result_t batch [$]);
    int  w;
    int  i;
    bit  same;
    open_run = 1'b0;
    if (run_count >= MAX_WORDS) begin
      dropped = 1'b1;
    end else begin
      for (w = 0; w < run_count; w++) begin
        same = (word_len[w] == open_len);
        for (i = 0; i < ALPHABET; i++)
          if (word_hist[w][i] != open_hist[i]) same = 1'b0;
        if (same) begin
          if (pair_count < PAIR_SAT) pair_count++;
          // one slot per byte is kept for the total report
          if (batch.size() < EMIT_CAP)
            batch.push_back(make_result(KIND_PAIR, word_start[w], word_len[w],
                                        open_start, open_len));
        end
      end
      for (i = 0; i < ALPHABET; i++) word_hist[run_count][i] = open_hist[i];
      word_start[run_count] = open_start;
      word_len[run_count]   = open_len;
      run_count++;
    end
  endtask

  // expected output words for one accepted input word
  task automatic predict_byte(input logic [7:0] c, input logic eot);
    pair_result_t batch [$];
    int           letter;
    int           i;
    letter = letter_index(c);
    if (text_pos >= MAX_CHARS) begin
      // past the end of the buffer: byte dropped
      dropped = 1'b1;
    end else begin
      if (letter >= 0) begin
        if (!open_run) begin
          open_run   = 1'b1;
          open_start = text_pos[START_W-1:0];
          open_len   = '0;
          for (i = 0; i < ALPHABET; i++) open_hist[i] = 8'd0;
        end
        open_hist[letter]++;
        open_len++;
      end else if (open_run) begin
        close_run(batch);
      end
      text_pos++;
    end
    if (eot) begin
      if (open_run) close_run(batch);
      batch.push_back(make_result(KIND_TOTAL, '0, '0, '0, '0));
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    for (i = 0; i < batch.size(); i++) pending_results.push_back(batch[i]);
    if (eot) clear_sentence();
  endtask

  // ------------------------------------------------------------------
  // stimulus builders
  // ------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c, input logic eot);
    text_byte_t t;
    t.c   = c;
    t.eot = eot;
    text_queue.push_back(t);
  endtask

  task automatic push_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_sep();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (letter_index(c) >= 0);
    return c;
  endfunction

  // a sentence of letter runs, mostly shuffles of a few base runs, cut at target bytes;
  // the cut may fall inside a run, so the final byte ends it
  task automatic add_sentence(input int target);
    logic [7:0] sent [$];
    logic [4:0] base [3][40];
    int         base_len [3];
    logic [4:0] w [40];
    logic [4:0] t;
    int         span;
    int         pick;
    int         len;
    int         n;
    int         b;
    int         i;
    int         j;
    // a narrow alphabet makes chance anagrams among fresh runs likely
    span = $urandom_range(1, 25);
    for (b = 0; b < 3; b++) begin
      base_len[b] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (i = 0; i < 40; i++) base[b][i] = 5'($urandom_range(0, span));
    end
    while (sent.size() < target) begin
      pick = $urandom_range(0, 3);
      if (pick < 3) begin
        len = base_len[pick];
        w   = base[pick];
        for (i = len - 1; i > 0; i--) begin
          j    = $urandom_range(0, i);
          t    = w[i];
          w[i] = w[j];
          w[j] = t;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) w[i] = 5'($urandom_range(0, span));
      end
      for (i = 0; i < len; i++)
        sent.push_back(($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'(w[i]));
      n = $urandom_range(1, 2);
      repeat (n) sent.push_back(rand_sep());
    end
    while (sent.size() > target) void'(sent.pop_back());
    for (i = 0; i < sent.size(); i++) push_byte(sent[i], i == sent.size() - 1);
  endtask

  // ------------------------------------------------------------------
  // driver: bursts of input words with random gaps
  // ------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive
    text_byte_t nxt;
    if (rst) begin
      in_valid    <= 1'b0;
      char_byte   <= 8'd0;
      end_of_text <= 1'b0;
      burst_left  <= 8;
      gap_left    <= 0;
    end else begin
      // predict on acceptance, from the word that was on the port
      if (in_valid && in_ready) predict_byte(char_byte, end_of_text);
      // valid is held until the word is taken
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || text_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          nxt = text_queue.pop_front();
          in_valid    <= 1'b1;
          char_byte   <= nxt.c;
          end_of_text <= nxt.eot;
          if (burst_left <= 1) begin
            // some long bursts with no idling, otherwise short ones
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: stall pattern on out_ready and in-order field checks
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  int          mode_phase = 0;
  stall_mode_e stall_mode = READY_ALWAYS;

  always @(posedge clk) begin : receive
    pair_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word, expected none actual kind %0d total %0d",
                   $time, result_kind, pair_total);
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("first_start", want.fs, first_start);
          check_field("first_length", want.fl, first_length);
          check_field("second_start", want.ss, second_start);
          check_field("second_length", want.sl, second_length);
          check_field("pair_total", want.total, pair_total);
          check_field("overflow_seen", want.ovf, overflow_seen);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // long hold-off: the sender keeps offering and the block backs up to its input
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        mode_phase++;
        case (stall_mode)
          READY_ALWAYS:       out_ready <= 1'b1;
          READY_COIN:         out_ready <= 1'($urandom_range(0, 1));
          READY_TWO_OF_THREE: out_ready <= (mode_phase % 3 != 0);
          default:            out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog: too long with nothing accepted on either side
  // ------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------
  initial begin
    int         random_items;
    int         before_size;
    int         nsent;
    int         k;
    int         n;
    logic [7:0] base_letter;
    clear_sentence();

    // directed: letter bounds against their neighbors, lone letters pairing across case,
    // a high byte as separator, the final byte ending an open run
    push_text("A@z[a`Z{ab", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("BA", 1'b1);
    // empty sentence: only the total report
    push_byte(8'h00, 1'b1);
    // digit and high byte as separators, final byte a separator
    push_text("Ba5ab", 1'b0);
    push_byte(8'h80, 1'b1);
    push_text("Listen7SILENT", 1'b1);

    random_items = 0;
    nsent        = 0;
    while (random_items < RANDOM_ITEMS) begin
      before_size = text_queue.size();
      if (nsent == 3) begin
        // 64 single-letter runs filling the buffer: 63 pairs plus the report on the last byte
        base_letter = 8'($urandom_range(0, 25));
        for (k = 0; k < MAX_WORDS; k++) begin
          push_byte(($urandom_range(0, 1) ? UPPER_A : LOWER_A) + base_letter, 1'b0);
          push_byte(rand_sep(), k == MAX_WORDS - 1);
        end
      end else if (nsent == 6) begin
        // runs past the end of the buffer: dropped bytes, end marker on a dropped byte
        add_sentence($urandom_range(MAX_CHARS + 1, MAX_CHARS + 12));
      end else if ($urandom_range(0, 4) == 0) begin
        // noise: any byte values, short
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) push_byte(8'($urandom_range(0, 255)), k == n - 1);
      end else begin
        add_sentence($urandom_range(6, 40));
      end
      random_items += text_queue.size() - before_size;
      nsent++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sample on the falling edge so the driver's updates have settled
    while (text_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    // trailing cycles: catch any stray output word
    repeat (200) @(negedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
